// File: rtl/task_slot_round_robin_scheduler_macros.svh
// Assertion helpers for the slot scheduler.
// TSRR_ASSERT: checked after reset is released.
// TSRR_ASSERT_ALWAYS: checked at every clock edge, reset included.
`ifndef TASK_SLOT_ROUND_ROBIN_SCHEDULER_MACROS_SVH
`define TASK_SLOT_ROUND_ROBIN_SCHEDULER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define TSRR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define TSRR_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TSRR_ASSERT(lbl, prop, msg)
`define TSRR_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: rtl/tsrr_pkg.sv
`default_nettype none
package tsrr_pkg;

	localparam int SLOT_COUNT   = 16;
	localparam int SLOT_W       = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int SLOT_FIELD_W = 4;
	localparam int ENTRY_W      = 32;
	localparam int RANK_W       = 8;
	localparam logic [RANK_W-1:0] RANK_LIMIT_RESET = 8'd31;

	typedef logic [SLOT_W-1:0]       slot_idx_t;
	typedef logic [SLOT_FIELD_W-1:0] slot_field_t;

	typedef enum logic [1:0] {
		OP_CREATE = 2'd0,
		OP_RUN    = 2'd1,
		OP_SCHED  = 2'd2,
		OP_DELETE = 2'd3
	} op_e;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_RANK     = 2'd1,
		ST_FULL     = 2'd2,
		ST_NOT_DEAD = 2'd3
	} status_e;

	typedef enum logic [1:0] {
		COND_FREE  = 2'd0,
		COND_DEAD  = 2'd1,
		COND_READY = 2'd2
	} cond_e;

	typedef enum logic [1:0] {
		ADDR_PTR = 2'd0,
		ADDR_RUN = 2'd1,
		ADDR_CUR = 2'd2
	} addr_sel_e;

	typedef enum logic [1:0] {
		SRC_ZERO = 2'd0,
		SRC_PTR  = 2'd1,
		SRC_RUN  = 2'd2,
		SRC_CUR  = 2'd3
	} slot_src_e;

	typedef enum logic [2:0] {
		S_IDLE  = 3'd0,
		S_CHECK = 3'd1,
		S_SCAN  = 3'd2,
		S_READ  = 3'd3,
		S_DONE  = 3'd4
	} state_e;

	typedef struct packed {
		logic      load;
		logic      scan_create;
		logic      scan_sched;
		logic      scan_step;
		addr_sel_e addr_sel;
		logic      cond_we;
		cond_e     cond_wval;
		logic      mem_we;
		logic      mem_re;
		logic      cur_we;
		logic      res_we;
		status_e   res_status;
		slot_src_e res_src;
		logic      push;
	} tsrr_cmd_t;

	typedef struct packed {
		op_e  op;
		logic rank_bad;
		logic run_ok;
		logic hit;
		logic last;
		logic out_busy;
	} tsrr_stat_t;

	// cyclic successor of a slot index
	function automatic slot_idx_t slot_next(input slot_idx_t x);
		slot_idx_t r;
		if (x == SLOT_W'(SLOT_COUNT - 1))
			r = '0;
		else
			r = x + 1'b1;
		return r;
	endfunction

endpackage
`default_nettype wire

// File: rtl/tsrr_ifs.sv
`default_nettype none
interface tsrr_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [7:0]  rank;
	logic [31:0] entry_address;
	logic [3:0]  run_slot;

	modport source (output valid, output op, output rank, output entry_address,
		output run_slot, input ready);
	modport sink (input valid, input op, input rank, input entry_address,
		input run_slot, output ready);
endinterface

interface tsrr_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [3:0]  slot;
	logic [31:0] current_entry;

	modport source (output valid, output status, output slot, output current_entry,
		input ready);
	modport sink (input valid, input status, input slot, input current_entry,
		output ready);
endinterface
`default_nettype wire

// File: rtl/tsrr_ctrl.sv
`default_nettype none
module tsrr_ctrl
	import tsrr_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire tsrr_stat_t st,
	output tsrr_cmd_t       cmd
);

	state_e state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d        = state_q;
		in_ready       = 1'b0;
		cmd            = '0;
		cmd.addr_sel   = ADDR_CUR;
		cmd.cond_wval  = COND_FREE;
		cmd.res_status = ST_OK;
		cmd.res_src    = SRC_ZERO;

		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				unique case (st.op)
					OP_CREATE: begin
						if (st.rank_bad) begin
							cmd.res_we     = 1'b1;
							cmd.res_status = ST_RANK;
							cmd.res_src    = SRC_ZERO;
							state_d        = S_READ;
						end else begin
							cmd.scan_create = 1'b1;
							state_d         = S_SCAN;
						end
					end
					OP_RUN: begin
						cmd.addr_sel   = ADDR_RUN;
						cmd.cond_we    = st.run_ok;
						cmd.cond_wval  = COND_READY;
						cmd.res_we     = 1'b1;
						cmd.res_status = st.run_ok ? ST_OK : ST_NOT_DEAD;
						cmd.res_src    = SRC_RUN;
						state_d        = S_READ;
					end
					OP_SCHED: begin
						cmd.scan_sched = 1'b1;
						state_d        = S_SCAN;
					end
					OP_DELETE: begin
						cmd.addr_sel  = ADDR_CUR;
						cmd.cond_we   = 1'b1;
						cmd.cond_wval = COND_FREE;
						cmd.res_we    = 1'b1;
						cmd.res_src   = SRC_CUR;
						state_d       = S_READ;
					end
				endcase
			end
			S_SCAN: begin
				cmd.addr_sel = ADDR_PTR;
				if (st.hit) begin
					cmd.res_we  = 1'b1;
					cmd.res_src = SRC_PTR;
					if (st.op == OP_CREATE) begin
						cmd.cond_we   = 1'b1;
						cmd.cond_wval = COND_DEAD;
						cmd.mem_we    = 1'b1;
					end else begin
						cmd.cur_we = 1'b1;
					end
					state_d = S_READ;
				end else if (st.last) begin
					cmd.res_we = 1'b1;
					if (st.op == OP_CREATE) begin
						cmd.res_status = ST_FULL;
						cmd.res_src    = SRC_ZERO;
					end else begin
						cmd.res_src = SRC_CUR;
					end
					state_d = S_READ;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			S_READ: begin
				cmd.addr_sel = ADDR_CUR;
				cmd.mem_re   = 1'b1;
				state_d      = S_DONE;
			end
			S_DONE: begin
				if (!st.out_busy) begin
					cmd.push = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule
`default_nettype wire

// File: rtl/tsrr_dp.sv
`default_nettype none
`include "task_slot_round_robin_scheduler_macros.svh"
module tsrr_dp
	import tsrr_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [RANK_W-1:0]    cfg_wdata,
	input  wire logic [1:0]           in_op,
	input  wire logic [RANK_W-1:0]    in_rank,
	input  wire logic [ENTRY_W-1:0]   in_entry,
	input  wire logic [SLOT_FIELD_W-1:0] in_run_slot,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [1:0]                out_status,
	output logic [SLOT_FIELD_W-1:0]   out_slot,
	output logic [ENTRY_W-1:0]        out_entry,
	input  wire tsrr_cmd_t            cmd,
	output tsrr_stat_t                st
);

	op_e                 op_q;
	logic [RANK_W-1:0]   rank_q;
	logic [ENTRY_W-1:0]  entry_q;
	slot_field_t         run_q;
	logic [RANK_W-1:0]   rank_limit_q;

	slot_idx_t           cur_q;
	slot_idx_t           ptr_q;
	slot_idx_t           cnt_q;
	cond_e               cond_q [SLOT_COUNT];
	logic [ENTRY_W-1:0]  mem [SLOT_COUNT];

	logic [ENTRY_W-1:0]  rd_entry_q;
	logic                cur_live_q;
	status_e             res_status_q;
	slot_field_t         res_slot_q;

	logic                out_valid_q;
	status_e             out_status_q;
	slot_field_t         out_slot_q;
	logic [ENTRY_W-1:0]  out_entry_q;

	slot_idx_t           addr;
	cond_e               cond_rd;
	cond_e               scan_target;
	logic                run_in_range;
	slot_field_t         res_slot_d;

	always_comb begin
		unique case (cmd.addr_sel)
			ADDR_PTR: addr = ptr_q;
			ADDR_RUN: addr = SLOT_W'(run_q);
			ADDR_CUR: addr = cur_q;
			default:  addr = cur_q;
		endcase
	end

	assign cond_rd      = cond_q[addr];
	assign scan_target  = (op_q == OP_CREATE) ? COND_FREE : COND_READY;
	assign run_in_range = (32'(run_q) < 32'(SLOT_COUNT));

	assign st.op       = op_q;
	// limit is rank_limit + 1 without wrap
	assign st.rank_bad = ({1'b0, rank_q} > ({1'b0, rank_limit_q} + 9'd1));
	assign st.run_ok   = run_in_range && (cond_rd == COND_DEAD);
	assign st.hit      = (cond_rd == scan_target);
	assign st.last     = (cnt_q == SLOT_W'(SLOT_COUNT - 1));
	assign st.out_busy = out_valid_q && !out_ready;

	always_comb begin
		unique case (cmd.res_src)
			SRC_ZERO: res_slot_d = '0;
			SRC_PTR:  res_slot_d = SLOT_FIELD_W'(ptr_q);
			SRC_RUN:  res_slot_d = run_q;
			SRC_CUR:  res_slot_d = SLOT_FIELD_W'(cur_q);
			default:  res_slot_d = '0;
		endcase
	end

	// operand capture and result staging
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= op_e'(in_op);
			rank_q  <= in_rank;
			entry_q <= in_entry;
			run_q   <= in_run_slot;
		end
		if (cmd.res_we) begin
			res_status_q <= cmd.res_status;
			res_slot_q   <= res_slot_d;
		end
		if (cmd.push) begin
			out_status_q <= res_status_q;
			out_slot_q   <= res_slot_q;
			out_entry_q  <= cur_live_q ? rd_entry_q : '0;
		end
	end

	// entry store, read registered
	always_ff @(posedge clk) begin
		if (cmd.mem_we)
			mem[ptr_q] <= entry_q;
		if (cmd.mem_re) begin
			rd_entry_q <= mem[cur_q];
			cur_live_q <= (cond_rd != COND_FREE);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++)
				cond_q[i] <= COND_FREE;
		end else if (cmd.cond_we) begin
			cond_q[addr] <= cmd.cond_wval;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_limit_q <= RANK_LIMIT_RESET;
			cur_q        <= '0;
			ptr_q        <= '0;
			cnt_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we)
				rank_limit_q <= cfg_wdata;
			if (cmd.cur_we)
				cur_q <= ptr_q;
			if (cmd.scan_create) begin
				ptr_q <= '0;
				cnt_q <= '0;
			end else if (cmd.scan_sched) begin
				// start one past current, current itself comes last
				ptr_q <= slot_next(cur_q);
				cnt_q <= '0;
			end else if (cmd.scan_step) begin
				ptr_q <= slot_next(ptr_q);
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.push)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_slot   = out_slot_q;
	assign out_entry  = out_entry_q;

	`TSRR_ASSERT(a_push_free, cmd.push |-> !(out_valid_q && !out_ready), "beat overwritten")
	`TSRR_ASSERT(a_dead_on_free, (cmd.cond_we && cmd.cond_wval == COND_DEAD) |-> cond_rd == COND_FREE, "create on used slot")
	`TSRR_ASSERT_ALWAYS(a_mem_with_create, cmd.mem_we |-> (cmd.cond_we && cmd.cond_wval == COND_DEAD), "entry write without create")
	`TSRR_ASSERT(a_ptr_range, 32'(ptr_q) < 32'(SLOT_COUNT), "scan pointer out of range")

endmodule
`default_nettype wire

// File: rtl/task_slot_round_robin_scheduler.sv
// channel   dir  beat fields
// task_in   in   op, rank, entry_address, run_slot
// result    out  status, slot, current_entry
// cfg       in   cfg_we / cfg_wdata -> rank limit, no handshake
//
// One item at a time. Run, delete and a rejected create go from accept through
// the check, read and done states to the result; create and schedule add a slot
// scan of 1 to SLOT_COUNT slots (one slot per cycle) between check and read.
// A result waiting on a stalled result channel does not block the next
// accept, but that item's result waits for the output register to empty.
// Reset frees all slots, clears the current slot and sets the rank limit to 31.
`default_nettype none
module task_slot_round_robin_scheduler
	import tsrr_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [RANK_W-1:0] cfg_wdata,
	tsrr_in_if.sink                task_in,
	tsrr_out_if.source             result
);

	tsrr_cmd_t  cmd;
	tsrr_stat_t st;
	logic       in_ready;

	assign task_in.ready = in_ready;

	tsrr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (task_in.valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	tsrr_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_op       (task_in.op),
		.in_rank     (task_in.rank),
		.in_entry    (task_in.entry_address),
		.in_run_slot (task_in.run_slot),
		.out_valid   (result.valid),
		.out_ready   (result.ready),
		.out_status  (result.status),
		.out_slot    (result.slot),
		.out_entry   (result.current_entry),
		.cmd         (cmd),
		.st          (st)
	);

endmodule
`default_nettype wire
